FILE: design/sti_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sti_pkg
// Shared types, constants and reset values for the scanline timing core.
// ----------------------------------------------------------------------------
package sti_pkg;

   localparam int NumCtrlRegsDefault = 11;

   localparam logic [1:0] ACT_TICK   = 2'd0;
   localparam logic [1:0] ACT_WRITE  = 2'd1;
   localparam logic [1:0] ACT_STATUS = 2'd2;
   localparam logic [1:0] ACT_SPRITE = 2'd3;

   localparam logic [0:0] CSR_CYCLES_PER_LINE = 1'd0;
   localparam logic [0:0] CSR_HANDHELD_MODE   = 1'd1;

   localparam logic [3:0] REG_MODE0  = 4'd0;
   localparam logic [3:0] REG_MODE1  = 4'd1;
   localparam logic [3:0] REG_SPRGEN = 4'd6;
   localparam logic [3:0] REG_VSCROLL = 4'd9;
   localparam logic [3:0] REG_LINECNT = 4'd10;

   localparam logic [8:0] LINE_VISIBLE    = 9'd192;
   localparam logic [8:0] LINE_FRAME_IRQ  = 9'd193;
   localparam logic [8:0] LINE_PORT_JUMP  = 9'd219;
   localparam logic [8:0] LINES_PER_FRAME = 9'd262;
   localparam logic [8:0] HH_FIRST        = 9'd24;
   localparam logic [8:0] HH_END          = 9'd168;
   localparam logic [7:0] PORT_JUMP_VALUE = 8'd213;
   localparam logic [8:0] ACC_MAX         = 9'd511;
   localparam logic [7:0] CPL_RESET       = 8'd228;
   localparam logic [7:0] LDC_RESET       = 8'hFF;
   localparam logic [7:0] STATUS_LOW_BITS = 8'h1F;

   typedef struct packed {
      logic [1:0] action;
      logic [6:0] cycle_count;
      logic [3:0] reg_index;
      logic [7:0] write_value;
      logic       overflow_seen;
      logic       collision_seen;
   } sti_item_type;

   typedef struct packed {
      logic [7:0] status_byte;
      logic       irq_request;
      logic [7:0] port_line_count;
      logic [7:0] scroll_latched;
      logic       render_strobe;
      logic [7:0] render_line;
   } sti_result_type;

   typedef struct packed {
      logic [7:0] cycles_per_line;
      logic       handheld_mode;
   } sti_cfg_type;

   function automatic logic [7:0] ctrl_reset_value(input logic [3:0] idx);
      logic [7:0] v;
      case (idx)
         REG_MODE0:  v = 8'h36;
         REG_MODE1:  v = 8'h80;
         REG_SPRGEN: v = 8'hFB;
         default:    v = 8'hFF;
      endcase
      return v;
   endfunction

endpackage

FILE: design/sti_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sti_engine
// Timing state, control registers and the one-pass update for each beat.
// ----------------------------------------------------------------------------
module sti_engine import sti_pkg::*; #(
   parameter int NUM_CTRL_REGS = NumCtrlRegsDefault
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           go,
   input  sti_item_type   item,
   input  sti_cfg_type    cfg,
   output sti_result_type result
);

   logic [8:0] acc_ff, acc_in;
   logic [8:0] line_ff, line_in;
   logic [7:0] port_ff, port_in;
   logic [7:0] ldc_ff, ldc_in;
   logic [7:0] scroll_ff, scroll_in;
   logic       frame_ff, frame_in;
   logic       linep_ff, linep_in;
   logic       ovf_ff, ovf_in;
   logic       col_ff, col_in;
   logic [7:0] ctrl_ff [NUM_CTRL_REGS];
   logic [7:0] ctrl_in [NUM_CTRL_REGS];

   logic [9:0] acc_sum;
   logic [8:0] acc_sat;
   logic [8:0] line_next;
   logic [7:0] ldc_dec;
   logic       active;

   always_comb begin
      acc_sum   = {1'b0, acc_ff} + {3'b0, item.cycle_count};
      acc_sat   = (acc_sum > {1'b0, ACC_MAX}) ? ACC_MAX : acc_sum[8:0];
      line_next = line_ff + 9'd1;
      ldc_dec   = ldc_ff - 8'd1;
      active    = !cfg.handheld_mode || (line_ff >= HH_FIRST && line_ff < HH_END);

      acc_in    = acc_ff;
      line_in   = line_ff;
      port_in   = port_ff;
      ldc_in    = ldc_ff;
      scroll_in = scroll_ff;
      frame_in  = frame_ff;
      linep_in  = linep_ff;
      ovf_in    = ovf_ff;
      col_in    = col_ff;
      ctrl_in   = ctrl_ff;
      result    = '0;

      case (item.action)
         ACT_TICK: begin
            acc_in = acc_sat;
            if (acc_sat >= {1'b0, cfg.cycles_per_line}) begin
               acc_in  = acc_sat - {1'b0, cfg.cycles_per_line};
               line_in = line_next;
               port_in = port_ff + 8'd1;
               if (line_ff < LINE_VISIBLE) begin
                  ldc_in = ldc_dec;
                  if (ldc_dec == 8'hFF) begin
                     linep_in = 1'b1;
                     ldc_in   = ctrl_ff[REG_LINECNT];
                  end
                  if (ctrl_ff[REG_MODE1][6] && active) begin
                     result.render_strobe = 1'b1;
                     result.render_line   = line_ff[7:0];
                  end
               end
               if (line_next == LINE_FRAME_IRQ) begin
                  frame_in  = 1'b1;
                  scroll_in = ctrl_ff[REG_VSCROLL];
                  ldc_in    = ctrl_ff[REG_LINECNT];
               end else if (line_next == LINE_PORT_JUMP) begin
                  port_in = PORT_JUMP_VALUE;
               end else if (line_next >= LINES_PER_FRAME) begin
                  line_in = '0;
                  port_in = '0;
               end
            end
         end
         ACT_WRITE: begin
            for (int i = 0; i < NUM_CTRL_REGS; i++) begin
               if (item.reg_index == 4'(i)) begin
                  ctrl_in[i] = item.write_value;
               end
            end
            if (line_ff >= LINE_VISIBLE) begin
               if (item.reg_index == REG_VSCROLL) begin
                  scroll_in = item.write_value;
               end
               if (item.reg_index == REG_LINECNT) begin
                  ldc_in = item.write_value;
               end
            end
         end
         ACT_STATUS: begin
            result.status_byte = STATUS_LOW_BITS | {frame_ff, ovf_ff, col_ff, 5'b0};
            frame_in = 1'b0;
            linep_in = 1'b0;
            ovf_in   = 1'b0;
            col_in   = 1'b0;
         end
         default: begin
            ovf_in = ovf_ff | item.overflow_seen;
            col_in = col_ff | item.collision_seen;
         end
      endcase

      result.irq_request     = (frame_in && ctrl_in[REG_MODE1][5])
                             || (linep_in && ctrl_in[REG_MODE0][4]);
      result.port_line_count = port_in;
      result.scroll_latched  = scroll_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff    <= '0;
         line_ff   <= '0;
         port_ff   <= '0;
         ldc_ff    <= LDC_RESET;
         scroll_ff <= '0;
         frame_ff  <= 1'b0;
         linep_ff  <= 1'b0;
         ovf_ff    <= 1'b0;
         col_ff    <= 1'b0;
         for (int i = 0; i < NUM_CTRL_REGS; i++) begin
            ctrl_ff[i] <= ctrl_reset_value(4'(i));
         end
      end else if (go) begin
         acc_ff    <= acc_in;
         line_ff   <= line_in;
         port_ff   <= port_in;
         ldc_ff    <= ldc_in;
         scroll_ff <= scroll_in;
         frame_ff  <= frame_in;
         linep_ff  <= linep_in;
         ovf_ff    <= ovf_in;
         col_ff    <= col_in;
         ctrl_ff   <= ctrl_in;
      end
   end

endmodule

FILE: design/scanline_timing_interrupts_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scanline_timing_interrupts_core
// Scanline timing and interrupt unit: line counting, interrupts, status.
// ----------------------------------------------------------------------------
// Takes one beat per clock while the rsp side keeps up and returns one result
// beat per input beat, in order. Each beat is held in the input register,
// where the whole state update is done in a single pass, and its result in
// the result register. While a result waits on a stalled rsp side, one more
// beat is taken into an empty input register; req_tready then stays low until
// the rsp side takes the waiting result.
module scanline_timing_interrupts_core import sti_pkg::*; #(
   parameter int NUM_CTRL_REGS = NumCtrlRegsDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [6:0] cycle_count, [10:7] reg_index, [18:11] write_value,
   // [19] overflow_seen, [20] collision_seen, [23:21] zero
   input  logic [23:0] req_tdata,
   // [1:0] action
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [7:0] status_byte, [8] irq_request, [16:9] port_line_count,
   // [24:17] scroll_latched, [25] render_strobe, [33:26] render_line,
   // [39:34] zero
   output logic [39:0] rsp_tdata,
   input  logic        csr_we,
   input  logic [0:0]  csr_index,
   input  logic [7:0]  csr_wdata
);

   logic           in_valid_ff;
   sti_item_type   item_ff;
   logic           out_valid_ff;
   sti_result_type result_ff;
   sti_result_type result;
   sti_cfg_type    cfg_ff;
   logic           advance;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {6'b0, result_ff.render_line, result_ff.render_strobe,
                        result_ff.scroll_latched, result_ff.port_line_count,
                        result_ff.irq_request, result_ff.status_byte};

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.cycles_per_line <= CPL_RESET;
         cfg_ff.handheld_mode   <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_CYCLES_PER_LINE: cfg_ff.cycles_per_line <= csr_wdata;
            CSR_HANDHELD_MODE:   cfg_ff.handheld_mode   <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tvalid && req_tready) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         item_ff.action         <= req_tuser;
         item_ff.cycle_count    <= req_tdata[6:0];
         item_ff.reg_index      <= req_tdata[10:7];
         item_ff.write_value    <= req_tdata[18:11];
         item_ff.overflow_seen  <= req_tdata[19];
         item_ff.collision_seen <= req_tdata[20];
      end
   end

   sti_engine #(
      .NUM_CTRL_REGS(NUM_CTRL_REGS)
   ) u_engine (
      .clock  (clock),
      .reset  (reset),
      .go     (advance),
      .item   (item_ff),
      .cfg    (cfg_ff),
      .result (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         result_ff <= result;
      end
   end

endmodule
